@@ rtl/core/oqr_pkg.sv @@
package oqr_pkg;

    // request kinds carried on s_tuser
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status carried on m_tuser
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // fixed field widths of the stream payload
    localparam int VALUE_PORT_W = 16;
    localparam int COUNT_PORT_W = 5;

    typedef struct packed {
        logic load;    // capture request and register match vector
        logic commit;  // update cells and load the result register
    } dp_cmd_t;

endpackage

@@ rtl/core/oqr_ctrl.sv @@
module oqr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output oqr_pkg::dp_cmd_t cmd
);
    import oqr_pkg::*;

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;

    assign s_tready   = (state_reg == IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign cmd.load   = s_tvalid && (state_reg == IDLE);
    // result register free, or its transaction completes this cycle
    assign cmd.commit = (state_reg == EXEC) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (cmd.load) begin
                        state_reg <= EXEC;
                    end
                end
                EXEC: begin
                    if (cmd.commit) begin
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/oqr_datapath.sv @@
module oqr_datapath #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  oqr_pkg::dp_cmd_t                    cmd,
    input  logic                                req_op,
    input  logic [oqr_pkg::VALUE_PORT_W-1:0]    req_value,
    output logic [1:0]                          res_status,
    output logic [oqr_pkg::COUNT_PORT_W-1:0]    res_count,
    output logic [oqr_pkg::VALUE_PORT_W-1:0]    res_head,
    output logic                                res_head_valid
);
    import oqr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [VALUE_WIDTH-1:0] cell_reg [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_next [DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   op_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [DEPTH-1:0]       match_reg;
    logic [DEPTH-1:0]       match_now;
    logic [DEPTH-1:0]       shift_mask;
    logic [VALUE_WIDTH-1:0] value_in;
    logic                   hit;
    logic                   is_full;
    logic                   is_empty;
    logic                   do_append;
    logic                   do_remove;
    logic [1:0]             status_next;

    logic [1:0]              status_reg;
    logic [COUNT_PORT_W-1:0] out_count_reg;
    logic [VALUE_PORT_W-1:0] out_head_reg;
    logic                    out_valid_reg;

    assign value_in = VALUE_WIDTH'(req_value);

    // every cell compares against the request in parallel
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match_now[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] == value_in);
        end
    end

    // ones from the first match toward the tail: m | -m
    assign shift_mask = match_reg | (~match_reg + 1'b1);
    assign hit        = |match_reg;
    assign is_full    = (count_reg == CNT_W'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign do_append  = (op_reg == OP_APPEND) && !is_full;
    assign do_remove  = (op_reg == OP_REMOVE) && !is_empty && hit;

    always_comb begin
        if (op_reg == OP_APPEND) begin
            status_next = is_full ? ST_FULL : ST_OK;
        end else if (is_empty) begin
            status_next = ST_EMPTY;
        end else if (!hit) begin
            status_next = ST_NOT_FOUND;
        end else begin
            status_next = ST_OK;
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_next[i] = cell_reg[i];
            if (do_append && (count_reg == CNT_W'(i))) begin
                cell_next[i] = val_reg;
            end
            if (do_remove && shift_mask[i] && (i < DEPTH - 1)) begin
                cell_next[i] = cell_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
        if (do_append) begin
            count_next = count_reg + 1'b1;
        end else if (do_remove) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= req_op;
            val_reg   <= value_in;
            match_reg <= match_now;
        end
        if (cmd.commit) begin
            for (int i = 0; i < DEPTH; i++) begin
                cell_reg[i] <= cell_next[i];
            end
            status_reg    <= status_next;
            out_count_reg <= COUNT_PORT_W'(count_next);
            out_valid_reg <= (count_next != '0);
            out_head_reg  <= (count_next != '0) ? VALUE_PORT_W'(cell_next[0]) : '0;
        end
    end

    assign res_status     = status_reg;
    assign res_count      = out_count_reg;
    assign res_head       = out_head_reg;
    assign res_head_valid = out_valid_reg;

endmodule

@@ rtl/core/ordered_queue_remove_by_value_core.sv @@
// Ordered queue with removal by value.
// Input stream: s_tuser selects the request (append at tail, or remove the
// first entry from the head that equals the value); s_tdata carries the value.
// Result stream: one transaction per request. m_tuser carries the status
// (ok, full on append, empty underflow, not found); m_tdata carries the entry
// count after the request, the head value (zero when empty) and a head valid
// flag.
// Each request runs as a load step, then a commit step: the accept edge
// registers the parallel compare of every cell against the value, and the
// commit edge shifts the cells behind the match (or writes the tail) and
// loads the result register, which drives the master side. No new request
// is taken before the current one commits.
// If the receiver stalls, the finished result waits in the output register;
// one further request is accepted and then holds until the register drains.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared.
module ordered_queue_remove_by_value_core #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [4:0] entry_count, [20:5] head_value,
                                   // [21] head_valid, [23:22] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import oqr_pkg::*;

    dp_cmd_t                 cmd;
    logic [COUNT_PORT_W-1:0] res_count;
    logic [VALUE_PORT_W-1:0] res_head;
    logic                    res_head_valid;

    oqr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    oqr_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .req_op         (s_tuser[0]),
        .req_value      (s_tdata),
        .res_status     (m_tuser),
        .res_count      (res_count),
        .res_head       (res_head),
        .res_head_valid (res_head_valid)
    );

    assign m_tdata = {2'b00, res_head_valid, res_head, res_count};

endmodule
